// File: sv/dse_pkg.sv
// Shared constants, types and command/status structs of the statistics engine.
package dse_pkg;

	localparam int MAX_SAMPLES = 32;
	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SAMPLE_W = 16;
	localparam int SUM_W = SAMPLE_W + IDX_W;
	localparam int PROD_W = SAMPLE_W + CNT_W + 1;
	localparam int DEV_W = PROD_W + 1;
	localparam int ABS_W = DEV_W - 1;
	localparam int SQ_W = 2 * ABS_W;
	localparam int SAB_W = ABS_W + CNT_W;
	localparam int DIVD_W = SQ_W + CNT_W;
	localparam int DIVR_W = 3 * CNT_W;
	localparam int DCNT_W = $clog2(DIVD_W + 1);
	localparam int RT_W = DIVD_W + 1;
	localparam int SD_W = (DIVD_W + 1) / 2;
	localparam int MEAN_W = SAMPLE_W + 1;
	localparam int VAL_W = DIVD_W + 2;
	localparam int OUT_W = 32;
	localparam int CV_SCALE = 25600;
	localparam int VAR_SHIFT = 8;

	typedef enum logic [3:0] {
		STAT_MEAN     = 4'd0,
		STAT_MEDIAN   = 4'd1,
		STAT_MIDRANGE = 4'd2,
		STAT_RANGE    = 4'd3,
		STAT_MAD      = 4'd4,
		STAT_VAR      = 4'd5,
		STAT_STDDEV   = 4'd6,
		STAT_CV       = 4'd7,
		STAT_MODE     = 4'd8
	} code_t;

	typedef enum logic [1:0] {DS_MEAN, DS_MAD, DS_VAR, DS_CV} dsel_t;

	typedef enum logic [2:0] {IX_MED_A, IX_MED_B, IX_LO, IX_HI, IX_SCAN} ix_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_DEV_CLR, OP_DEV_MUL, OP_DEV_ABS, OP_DEV_SQ, OP_DEV_ACC,
		OP_N2, OP_DEN
	} op_t;

	typedef enum logic [2:0] {
		EV_QUOT, EV_AVG, EV_DIFF, EV_VAR, EV_SD, EV_MAX, EV_MODE
	} ev_t;

	typedef struct packed {
		logic  load;
		logic  clear;
		logic  div_start;
		dsel_t div_sel;
		logic  sqrt_start;
		logic  cv_mul;
		ix_t   ix_sel;
		logic  lat_a;
		logic  lat_b;
		op_t   op;
		logic  scan_clr;
		logic  best_clr;
		logic  best_step;
		logic  mode_step;
		logic  emit;
		ev_t   ev_sel;
		code_t code;
		logic  last;
		logic  lat_mean;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic out_free;
		logic scan_end;
		logic den_zero;
		logic mean_zero;
	} status_t;

endpackage

// File: sv/dse_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module dse_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dse_pkg::DIVD_W-1:0]    dividend,
	input  logic [dse_pkg::DIVR_W-1:0]    divisor,
	output logic                          busy,
	output logic [dse_pkg::DIVD_W-1:0]    quot
);

	logic [dse_pkg::DIVD_W-1:0] quot_q;
	logic [dse_pkg::DIVR_W-1:0] rem_q;
	logic [dse_pkg::DIVR_W-1:0] dvs_q;
	logic [dse_pkg::DCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic [dse_pkg::DIVR_W:0]   shifted;
	logic [dse_pkg::DIVR_W:0]   trial;
	logic                       fits;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, quot_q[dse_pkg::DIVD_W-1]};
		trial = shifted - {1'b0, dvs_q};
		fits = (shifted >= {1'b0, dvs_q});
	end

	// Hold the busy flag and the step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= dse_pkg::DCNT_W'(dse_pkg::DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == dse_pkg::DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Advance the remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[dse_pkg::DIVD_W-2:0], fits};
			rem_q <= fits ? trial[dse_pkg::DIVR_W-1:0] : shifted[dse_pkg::DIVR_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

// File: sv/dse_sqrt.sv
// Floor integer square root, one result bit per cycle.
module dse_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dse_pkg::DIVD_W-1:0]   radicand,
	output logic                         busy,
	output logic [dse_pkg::SD_W-1:0]     root
);

	localparam int TOP_BIT = ((dse_pkg::DIVD_W - 1) / 2) * 2;

	logic [dse_pkg::RT_W-1:0] x_q;
	logic [dse_pkg::RT_W-1:0] res_q;
	logic [dse_pkg::RT_W-1:0] bit_q;
	logic                     busy_q;
	logic [dse_pkg::RT_W-1:0] trial;
	logic                     fits;

	always_comb begin
		trial = res_q + bit_q;
		fits = (x_q >= trial);
	end

	// Hold busy until the probe bit runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (bit_q[dse_pkg::RT_W-1:2] == '0)) begin
			busy_q <= 1'b0;
		end
	end

	// Advance one digit of the root
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dse_pkg::RT_W'(radicand);
			res_q <= '0;
			bit_q <= dse_pkg::RT_W'(1) << TOP_BIT;
		end else if (busy_q) begin
			if (fits) begin
				x_q <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[dse_pkg::SD_W-1:0];

endmodule

// File: sv/dse_dp.sv
// Datapath: sorted sample cells, accumulators, divider, square root, result register.
module dse_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [dse_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                cfg_we,
	input  logic                                cfg_data,
	input  dse_pkg::cmd_t                       cmd,
	output dse_pkg::status_t                    st,
	input  logic                                stat_stall,
	output logic                                stat_valid,
	output logic [3:0]                          stat_code,
	output logic signed [dse_pkg::OUT_W-1:0]    stat_value,
	output logic                                saturated,
	output logic                                dropped,
	output logic                                last_result
);

	localparam logic signed [dse_pkg::VAL_W-1:0] I32_MAX_V =
		dse_pkg::VAL_W'(32'sh7FFF_FFFF);
	localparam logic signed [dse_pkg::VAL_W-1:0] I32_MIN_V = -I32_MAX_V - 1;

	// Sorted sample cells and load state
	logic signed [dse_pkg::SAMPLE_W-1:0] cells_q [dse_pkg::MAX_SAMPLES];
	logic signed [dse_pkg::SAMPLE_W-1:0] cells_d [dse_pkg::MAX_SAMPLES];
	logic [dse_pkg::MAX_SAMPLES-1:0]     gt;
	logic [dse_pkg::CNT_W-1:0]           cnt_q;
	logic signed [dse_pkg::SUM_W-1:0]    sum_q;
	logic                                ovf_q;
	logic                                mode_q;
	logic                                full;

	// Read port
	logic [dse_pkg::IDX_W-1:0]           rd_idx;
	logic signed [dse_pkg::SAMPLE_W-1:0] rd_x;
	logic [dse_pkg::CNT_W-1:0]           mid;
	logic signed [dse_pkg::SAMPLE_W-1:0] a_q;
	logic signed [dse_pkg::SAMPLE_W-1:0] b_q;

	// Deviation sums
	logic signed [dse_pkg::PROD_W-1:0]   prod_w;
	logic signed [dse_pkg::PROD_W-1:0]   p_q;
	logic signed [dse_pkg::DEV_W-1:0]    dev_w;
	logic [dse_pkg::ABS_W-1:0]           abs_q;
	logic [dse_pkg::SQ_W-1:0]            sq_q;
	logic [dse_pkg::SAB_W-1:0]           sum_abs_q;
	logic [dse_pkg::DIVD_W-1:0]          sum_sq_q;
	logic [2*dse_pkg::CNT_W-1:0]         n2_q;
	logic [dse_pkg::DIVR_W-1:0]          den_q;
	logic [dse_pkg::CNT_W-1:0]           divv;

	// Divider and root
	logic [dse_pkg::DIVD_W-1:0]          div_dvd;
	logic [dse_pkg::DIVR_W-1:0]          div_dvs;
	logic                                div_busy;
	logic [dse_pkg::DIVD_W-1:0]          quot;
	logic                                sqrt_busy;
	logic [dse_pkg::SD_W-1:0]            root;
	logic                                sign_q;
	logic signed [dse_pkg::MEAN_W-1:0]   mean_q;
	logic [dse_pkg::MEAN_W-1:0]          mean_abs;
	logic [dse_pkg::DIVD_W-1:0]          cvp_q;

	// Mode scan
	logic [dse_pkg::IDX_W-1:0]           idx_q;
	logic [dse_pkg::CNT_W-1:0]           run_q;
	logic [dse_pkg::CNT_W-1:0]           best_q;
	logic [dse_pkg::CNT_W-1:0]           run_next;
	logic signed [dse_pkg::SAMPLE_W-1:0] prev_q;
	logic signed [dse_pkg::SAMPLE_W-1:0] pend_q;
	logic                                have_pend_q;
	logic                                hit;
	logic                                mode_emit;

	// Result formation
	logic signed [dse_pkg::VAL_W-1:0]    ev;
	logic signed [dse_pkg::VAL_W-1:0]    qv;
	logic signed [dse_pkg::SAMPLE_W:0]   pair_sum;
	logic signed [dse_pkg::SAMPLE_W:0]   pair_adj;
	logic signed [dse_pkg::VAL_W-1:0]    ev_clamped;
	logic                                ev_sat;
	logic                                out_free;

	logic                                stat_valid_q;
	logic [3:0]                          stat_code_q;
	logic signed [dse_pkg::OUT_W-1:0]    stat_value_q;
	logic                                sat_q;
	logic                                dropped_q;
	logic                                last_q;

	assign full = (cnt_q == dse_pkg::CNT_W'(dse_pkg::MAX_SAMPLES));

	// Insert the new sample into its sorted place; empty cells count as larger
	always_comb begin
		for (int i = 0; i < dse_pkg::MAX_SAMPLES; i++) begin
			gt[i] = (dse_pkg::CNT_W'(i) >= cnt_q) || (cells_q[i] > sample_value);
		end
		for (int i = 0; i < dse_pkg::MAX_SAMPLES; i++) begin
			if (!gt[i]) begin
				cells_d[i] = cells_q[i];
			end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
			end else begin
				cells_d[i] = sample_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			cells_q <= cells_d;
		end
	end

	// Hold count, running sum, drop flag and mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (cmd.clear) begin
				cnt_q <= '0;
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_q + dse_pkg::SUM_W'(sample_value);
				end
			end
		end
	end

	// Select the cell to read
	assign mid = cnt_q >> 1;
	always_comb begin
		case (cmd.ix_sel)
			dse_pkg::IX_MED_A: rd_idx = cnt_q[0] ? mid[dse_pkg::IDX_W-1:0]
				: dse_pkg::IDX_W'(mid - 1'b1);
			dse_pkg::IX_MED_B: rd_idx = mid[dse_pkg::IDX_W-1:0];
			dse_pkg::IX_LO:    rd_idx = '0;
			dse_pkg::IX_HI:    rd_idx = dse_pkg::IDX_W'(cnt_q - 1'b1);
			dse_pkg::IX_SCAN:  rd_idx = idx_q;
			default:           rd_idx = idx_q;
		endcase
	end
	assign rd_x = cells_q[rd_idx];

	always_ff @(posedge clk) begin
		if (cmd.lat_a) begin
			a_q <= rd_x;
		end
		if (cmd.lat_b) begin
			b_q <= rd_x;
		end
	end

	// Deviation pipeline: n*x, |n*x - sum|, square, accumulate
	assign prod_w = $signed(dse_pkg::PROD_W'({1'b0, cnt_q})) * dse_pkg::PROD_W'(rd_x);
	assign dev_w = dse_pkg::DEV_W'(p_q) - dse_pkg::DEV_W'(sum_q);
	assign divv = mode_q ? cnt_q : cnt_q - 1'b1;

	always_ff @(posedge clk) begin
		case (cmd.op)
			dse_pkg::OP_DEV_CLR: begin
				sum_abs_q <= '0;
				sum_sq_q <= '0;
			end
			dse_pkg::OP_DEV_MUL: p_q <= prod_w;
			dse_pkg::OP_DEV_ABS: begin
				abs_q <= dev_w[dse_pkg::DEV_W-1] ? dse_pkg::ABS_W'(-dev_w)
					: dse_pkg::ABS_W'(dev_w);
				sum_abs_q <= sum_abs_q + dse_pkg::SAB_W'(dev_w[dse_pkg::DEV_W-1]
					? dse_pkg::ABS_W'(-dev_w) : dse_pkg::ABS_W'(dev_w));
			end
			dse_pkg::OP_DEV_SQ:  sq_q <= abs_q * abs_q;
			dse_pkg::OP_DEV_ACC: sum_sq_q <= sum_sq_q + dse_pkg::DIVD_W'(sq_q);
			dse_pkg::OP_N2:      n2_q <= cnt_q * cnt_q;
			dse_pkg::OP_DEN:     den_q <= dse_pkg::DIVR_W'(n2_q) * dse_pkg::DIVR_W'(divv);
			default: ;
		endcase
		if (cmd.cv_mul) begin
			cvp_q <= dse_pkg::DIVD_W'(root) * dse_pkg::DIVD_W'(dse_pkg::CV_SCALE);
		end
	end

	// Pick divider operands and remember the quotient sign
	assign mean_abs = mean_q[dse_pkg::MEAN_W-1] ? dse_pkg::MEAN_W'(-mean_q)
		: dse_pkg::MEAN_W'(mean_q);
	always_comb begin
		case (cmd.div_sel)
			dse_pkg::DS_MEAN: begin
				div_dvd = dse_pkg::DIVD_W'($unsigned(sum_q[dse_pkg::SUM_W-1]
					? -sum_q : sum_q));
				div_dvs = dse_pkg::DIVR_W'(cnt_q);
			end
			dse_pkg::DS_MAD: begin
				div_dvd = dse_pkg::DIVD_W'(sum_abs_q);
				div_dvs = dse_pkg::DIVR_W'(n2_q);
			end
			dse_pkg::DS_VAR: begin
				div_dvd = sum_sq_q;
				div_dvs = den_q;
			end
			default: begin
				div_dvd = cvp_q;
				div_dvs = dse_pkg::DIVR_W'(mean_abs);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			case (cmd.div_sel)
				dse_pkg::DS_MEAN: sign_q <= sum_q[dse_pkg::SUM_W-1];
				dse_pkg::DS_CV:   sign_q <= mean_q[dse_pkg::MEAN_W-1];
				default:          sign_q <= 1'b0;
			endcase
		end
		if (cmd.lat_mean) begin
			mean_q <= qv[dse_pkg::MEAN_W-1:0];
		end
	end

	dse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (quot)
	);

	dse_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (quot),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// Run-length scan over the sorted cells
	assign run_next = ((idx_q == '0) || (rd_x != prev_q)) ? dse_pkg::CNT_W'(1)
		: run_q + 1'b1;
	assign hit = (run_next == best_q);
	assign mode_emit = cmd.mode_step && hit && have_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			run_q <= '0;
			best_q <= '0;
			have_pend_q <= 1'b0;
		end else begin
			if (cmd.best_clr) begin
				best_q <= '0;
			end else if (cmd.best_step && run_next > best_q) begin
				best_q <= run_next;
			end
			if (cmd.scan_clr || cmd.op == dse_pkg::OP_DEV_CLR) begin
				idx_q <= '0;
				run_q <= '0;
				have_pend_q <= 1'b0;
			end else if (cmd.best_step || cmd.mode_step) begin
				idx_q <= idx_q + 1'b1;
				run_q <= run_next;
				if (cmd.mode_step && hit) begin
					have_pend_q <= 1'b1;
				end
			end else if (cmd.op == dse_pkg::OP_DEV_ACC) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.best_step || cmd.mode_step) begin
			prev_q <= rd_x;
		end
		if (cmd.mode_step && hit) begin
			pend_q <= rd_x;
		end
	end

	// Form the statistic value, then clamp to 32 bits
	always_comb begin
		qv = $signed(dse_pkg::VAL_W'(quot));
		if (sign_q) begin
			qv = -qv;
		end
		pair_sum = (dse_pkg::SAMPLE_W + 1)'(a_q) + (dse_pkg::SAMPLE_W + 1)'(b_q);
		pair_adj = pair_sum + $signed({{dse_pkg::SAMPLE_W{1'b0}},
			pair_sum[dse_pkg::SAMPLE_W]});
		case (cmd.ev_sel)
			dse_pkg::EV_QUOT: ev = qv;
			dse_pkg::EV_AVG:  ev = dse_pkg::VAL_W'(pair_adj >>> 1);
			dse_pkg::EV_DIFF: ev = dse_pkg::VAL_W'(b_q) - dse_pkg::VAL_W'(a_q);
			dse_pkg::EV_VAR:  ev = $signed(dse_pkg::VAL_W'(quot >> dse_pkg::VAR_SHIFT));
			dse_pkg::EV_SD:   ev = $signed(dse_pkg::VAL_W'(root));
			dse_pkg::EV_MAX:  ev = I32_MAX_V;
			dse_pkg::EV_MODE: ev = dse_pkg::VAL_W'(pend_q);
			default:          ev = I32_MAX_V;
		endcase
		ev_sat = (cmd.ev_sel == dse_pkg::EV_MAX);
		ev_clamped = ev;
		if (ev > I32_MAX_V) begin
			ev_clamped = I32_MAX_V;
			ev_sat = 1'b1;
		end else if (ev < I32_MIN_V) begin
			ev_clamped = I32_MIN_V;
			ev_sat = 1'b1;
		end
	end

	// Result register: load a new transaction when the slot is free
	assign out_free = !stat_valid_q || !stat_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_valid_q <= 1'b0;
		end else if (cmd.emit || mode_emit) begin
			stat_valid_q <= 1'b1;
		end else if (!stat_stall) begin
			stat_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mode_emit) begin
			stat_code_q <= dse_pkg::STAT_MODE;
			stat_value_q <= dse_pkg::OUT_W'(pend_q);
			sat_q <= 1'b0;
			dropped_q <= ovf_q;
			last_q <= 1'b0;
		end else if (cmd.emit) begin
			stat_code_q <= cmd.code;
			stat_value_q <= ev_clamped[dse_pkg::OUT_W-1:0];
			sat_q <= ev_sat;
			dropped_q <= ovf_q;
			last_q <= cmd.last;
		end
	end

	assign st.div_busy = div_busy;
	assign st.sqrt_busy = sqrt_busy;
	assign st.out_free = out_free;
	assign st.scan_end = (dse_pkg::CNT_W'(idx_q) == cnt_q - 1'b1);
	assign st.den_zero = (den_q == '0);
	assign st.mean_zero = (mean_q == '0);

	assign stat_valid = stat_valid_q;
	assign stat_code = stat_code_q;
	assign stat_value = stat_value_q;
	assign saturated = sat_q;
	assign dropped = dropped_q;
	assign last_result = last_q;

endmodule

// File: sv/dse_ctrl.sv
// Controller: sequences sample loading and the statistics run.
module dse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               is_last,
	output logic               sample_stall,
	input  dse_pkg::status_t   st,
	output dse_pkg::cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_LOAD, S_MEAN_GO, S_MEAN_WAIT, S_MED_A, S_MED_B, S_MED_EMIT,
		S_MR_A, S_MR_B, S_MR_EMIT, S_RANGE_EMIT, S_DEV_CLR, S_DEV_MUL,
		S_DEV_ABS, S_DEV_SQ, S_DEV_ACC, S_N2, S_DEN, S_MAD_GO, S_MAD_WAIT,
		S_VAR_CHK, S_VAR_WAIT, S_SD_WAIT, S_CV_CHK, S_CV_GO, S_CV_WAIT,
		S_Z_VAR, S_Z_SD, S_Z_CV, S_MODE_INIT, S_MODE_BEST, S_MODE_SCAN,
		S_MODE_LAST
	} state_t;

	state_t state_q;

	assign sample_stall = (state_q != S_LOAD);

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_LOAD: cmd.load = sample_valid;
			S_MEAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = dse_pkg::DS_MEAN;
			end
			S_MEAN_WAIT: begin
				cmd.ev_sel = dse_pkg::EV_QUOT;
				cmd.code = dse_pkg::STAT_MEAN;
				cmd.emit = !st.div_busy && st.out_free;
				cmd.lat_mean = cmd.emit;
			end
			S_MED_A: begin
				cmd.ix_sel = dse_pkg::IX_MED_A;
				cmd.lat_a = 1'b1;
			end
			S_MED_B: begin
				cmd.ix_sel = dse_pkg::IX_MED_B;
				cmd.lat_b = 1'b1;
			end
			S_MED_EMIT: begin
				cmd.ev_sel = dse_pkg::EV_AVG;
				cmd.code = dse_pkg::STAT_MEDIAN;
				cmd.emit = st.out_free;
			end
			S_MR_A: begin
				cmd.ix_sel = dse_pkg::IX_LO;
				cmd.lat_a = 1'b1;
			end
			S_MR_B: begin
				cmd.ix_sel = dse_pkg::IX_HI;
				cmd.lat_b = 1'b1;
			end
			S_MR_EMIT: begin
				cmd.ev_sel = dse_pkg::EV_AVG;
				cmd.code = dse_pkg::STAT_MIDRANGE;
				cmd.emit = st.out_free;
			end
			S_RANGE_EMIT: begin
				cmd.ev_sel = dse_pkg::EV_DIFF;
				cmd.code = dse_pkg::STAT_RANGE;
				cmd.emit = st.out_free;
			end
			S_DEV_CLR: cmd.op = dse_pkg::OP_DEV_CLR;
			S_DEV_MUL: begin
				cmd.ix_sel = dse_pkg::IX_SCAN;
				cmd.op = dse_pkg::OP_DEV_MUL;
			end
			S_DEV_ABS: cmd.op = dse_pkg::OP_DEV_ABS;
			S_DEV_SQ:  cmd.op = dse_pkg::OP_DEV_SQ;
			S_DEV_ACC: cmd.op = dse_pkg::OP_DEV_ACC;
			S_N2:      cmd.op = dse_pkg::OP_N2;
			S_DEN:     cmd.op = dse_pkg::OP_DEN;
			S_MAD_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = dse_pkg::DS_MAD;
			end
			S_MAD_WAIT: begin
				cmd.ev_sel = dse_pkg::EV_QUOT;
				cmd.code = dse_pkg::STAT_MAD;
				cmd.emit = !st.div_busy && st.out_free;
			end
			S_VAR_CHK: begin
				cmd.div_sel = dse_pkg::DS_VAR;
				cmd.div_start = !st.den_zero;
			end
			S_VAR_WAIT: begin
				cmd.ev_sel = dse_pkg::EV_VAR;
				cmd.code = dse_pkg::STAT_VAR;
				cmd.emit = !st.div_busy && st.out_free;
				cmd.sqrt_start = cmd.emit;
			end
			S_SD_WAIT: begin
				cmd.ev_sel = dse_pkg::EV_SD;
				cmd.code = dse_pkg::STAT_STDDEV;
				cmd.emit = !st.sqrt_busy && st.out_free;
				cmd.cv_mul = cmd.emit;
			end
			S_CV_CHK: begin
				cmd.ev_sel = dse_pkg::EV_MAX;
				cmd.code = dse_pkg::STAT_CV;
				cmd.emit = st.mean_zero && st.out_free;
			end
			S_CV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = dse_pkg::DS_CV;
			end
			S_CV_WAIT: begin
				cmd.ev_sel = dse_pkg::EV_QUOT;
				cmd.code = dse_pkg::STAT_CV;
				cmd.emit = !st.div_busy && st.out_free;
			end
			S_Z_VAR: begin
				cmd.ev_sel = dse_pkg::EV_MAX;
				cmd.code = dse_pkg::STAT_VAR;
				cmd.emit = st.out_free;
			end
			S_Z_SD: begin
				cmd.ev_sel = dse_pkg::EV_MAX;
				cmd.code = dse_pkg::STAT_STDDEV;
				cmd.emit = st.out_free;
			end
			S_Z_CV: begin
				cmd.ev_sel = dse_pkg::EV_MAX;
				cmd.code = dse_pkg::STAT_CV;
				cmd.emit = st.out_free;
			end
			S_MODE_INIT: begin
				cmd.scan_clr = 1'b1;
				cmd.best_clr = 1'b1;
			end
			S_MODE_BEST: begin
				cmd.ix_sel = dse_pkg::IX_SCAN;
				cmd.best_step = 1'b1;
				cmd.scan_clr = st.scan_end;
			end
			S_MODE_SCAN: begin
				cmd.ix_sel = dse_pkg::IX_SCAN;
				cmd.mode_step = st.out_free;
			end
			S_MODE_LAST: begin
				cmd.ev_sel = dse_pkg::EV_MODE;
				cmd.code = dse_pkg::STAT_MODE;
				cmd.last = 1'b1;
				cmd.emit = st.out_free;
				cmd.clear = st.out_free;
			end
			default: ;
		endcase
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			case (state_q)
				S_LOAD: if (sample_valid && is_last) state_q <= S_MEAN_GO;
				S_MEAN_GO: state_q <= S_MEAN_WAIT;
				S_MEAN_WAIT: if (cmd.emit) state_q <= S_MED_A;
				S_MED_A: state_q <= S_MED_B;
				S_MED_B: state_q <= S_MED_EMIT;
				S_MED_EMIT: if (cmd.emit) state_q <= S_MR_A;
				S_MR_A: state_q <= S_MR_B;
				S_MR_B: state_q <= S_MR_EMIT;
				S_MR_EMIT: if (cmd.emit) state_q <= S_RANGE_EMIT;
				S_RANGE_EMIT: if (cmd.emit) state_q <= S_DEV_CLR;
				S_DEV_CLR: state_q <= S_DEV_MUL;
				S_DEV_MUL: state_q <= S_DEV_ABS;
				S_DEV_ABS: state_q <= S_DEV_SQ;
				S_DEV_SQ: state_q <= S_DEV_ACC;
				S_DEV_ACC: state_q <= st.scan_end ? S_N2 : S_DEV_MUL;
				S_N2: state_q <= S_DEN;
				S_DEN: state_q <= S_MAD_GO;
				S_MAD_GO: state_q <= S_MAD_WAIT;
				S_MAD_WAIT: if (cmd.emit) state_q <= S_VAR_CHK;
				S_VAR_CHK: state_q <= st.den_zero ? S_Z_VAR : S_VAR_WAIT;
				S_VAR_WAIT: if (cmd.emit) state_q <= S_SD_WAIT;
				S_SD_WAIT: if (cmd.emit) state_q <= S_CV_CHK;
				S_CV_CHK: begin
					if (!st.mean_zero) begin
						state_q <= S_CV_GO;
					end else if (cmd.emit) begin
						state_q <= S_MODE_INIT;
					end
				end
				S_CV_GO: state_q <= S_CV_WAIT;
				S_CV_WAIT: if (cmd.emit) state_q <= S_MODE_INIT;
				S_Z_VAR: if (cmd.emit) state_q <= S_Z_SD;
				S_Z_SD: if (cmd.emit) state_q <= S_Z_CV;
				S_Z_CV: if (cmd.emit) state_q <= S_MODE_INIT;
				S_MODE_INIT: state_q <= S_MODE_BEST;
				S_MODE_BEST: if (st.scan_end) state_q <= S_MODE_SCAN;
				S_MODE_SCAN: if (cmd.mode_step && st.scan_end) state_q <= S_MODE_LAST;
				S_MODE_LAST: if (cmd.emit) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// File: sv/descriptive_statistics_engine.sv
// Throughput: samples enter one per cycle while sample_stall is low; the run is paced by the
//   shared one-bit-per-cycle divider, the one-digit-per-cycle square root and the cell scans.
// Results leave through a one-deep output register; the run waits while it is stalled.
// Reset clears the sample count, running sum, drop flag and sample_mode; no clearing pass.
module descriptive_statistics_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [dse_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                                is_last,
	output logic                                stat_valid,
	input  logic                                stat_stall,
	output logic [3:0]                          stat_code,
	output logic signed [dse_pkg::OUT_W-1:0]    stat_value,
	output logic                                saturated,
	output logic                                dropped,
	output logic                                last_result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data
);

	dse_pkg::cmd_t    cmd;
	dse_pkg::status_t st;

	// Configuration writes are taken at any time
	assign cfg_ready = 1'b1;

	dse_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.is_last      (is_last),
		.sample_stall (sample_stall),
		.st           (st),
		.cmd          (cmd)
	);

	dse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_value (sample_value),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.st           (st),
		.stat_stall   (stat_stall),
		.stat_valid   (stat_valid),
		.stat_code    (stat_code),
		.stat_value   (stat_value),
		.saturated    (saturated),
		.dropped      (dropped),
		.last_result  (last_result)
	);

endmodule
